// ----- rtl/core/rgbhsl_pkg.sv -----
`timescale 1ns / 1ps

package rgbhsl_pkg;

    // Field widths of the pixel channels and of the results.
    localparam int unsigned CHAN_W = 8;
    localparam int unsigned HUE_W  = 9;
    localparam int unsigned PCT_W  = 7;

    // Divider geometry: one quotient bit per cell, most significant first.
    localparam int unsigned QUO_W  = 9;
    localparam int unsigned REM_W  = 17;
    localparam int unsigned DIV_W  = 9;

    // Constants of the colour conversion.
    localparam logic [DIV_W-1:0] LUM_DIVISOR = 9'd510;
    localparam logic [8:0]       CHAN_FULL   = 9'd255;
    localparam logic [8:0]       CHAN_TWICE  = 9'd510;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] alpha_in;
    } t_pixel_in;

    typedef struct packed {
        logic [HUE_W-1:0]  hue_deg;
        logic [PCT_W-1:0]  sat_pct;
        logic [PCT_W-1:0]  lum_pct;
        logic [CHAN_W-1:0] alpha_out;
    } t_pixel_out;

    // One division in flight: partial remainder, divisor and quotient so far.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] div;
        logic [QUO_W-1:0] quo;
    } t_lane;

    // Everything a cell of the chain holds for one pixel.
    typedef struct packed {
        t_lane             hue;
        t_lane             sat;
        t_lane             lum;
        logic [CHAN_W-1:0] alpha;
    } t_cell_data;

    // One restoring-division step at quotient bit position sh.
    function automatic t_lane div_step(input t_lane l, input int unsigned sh);
        logic [REM_W:0] trial;
        t_lane          res;
        trial = {1'b0, l.rem} - ((REM_W+1)'(l.div) << sh);
        res   = l;
        if (!trial[REM_W]) begin
            res.rem = trial[REM_W-1:0];
        end
        res.quo = {l.quo[QUO_W-2:0], ~trial[REM_W]};
        return res;
    endfunction

endpackage

// ----- rtl/core/rgb_to_hsl_converter.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i_in_data  (red, green, blue, alpha)
// out       output     o_out_valid / i_out_stall  o_out_data (hue, sat, lum, alpha)
//
// One pixel transaction is accepted every clock while o_in_stall is low. Its result
// passes through the entry stage and the nine-cell divider chain, ten registers in all.
// Reset (i_rst_n low, synchronous) empties every stage; no clearing pass is needed.
// A stall on the output holds the last cell; stalls travel upstream only through
// full stages, so bubbles are squeezed out; unless stalled, throughput is one per cycle.

module rgb_to_hsl_converter (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  rgbhsl_pkg::t_pixel_in  i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output rgbhsl_pkg::t_pixel_out o_out_data
);

    localparam int unsigned NCELL = rgbhsl_pkg::QUO_W;

    // Link k feeds cell k; link 0 comes from the entry stage.
    logic                   link_valid [NCELL+1];
    logic                   link_stall [NCELL+1];
    rgbhsl_pkg::t_cell_data link_data  [NCELL+1];

    // The entry stage finds max, min, their difference and sum, and the hue
    // sextant, then loads three numerator/divisor pairs for the chain.
    rgbhsl_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_stall (o_in_stall),
        .o_valid (link_valid[0]),
        .o_data  (link_data[0]),
        .i_stall (link_stall[0])
    );

    // Each cell performs one restoring-division step for hue, saturation and
    // luminance at once, most significant quotient bit first.
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        rgbhsl_cell #(
            .SHIFT (NCELL - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (link_valid[k]),
            .i_data  (link_data[k]),
            .o_stall (link_stall[k]),
            .o_valid (link_valid[k+1]),
            .o_data  (link_data[k+1]),
            .i_stall (link_stall[k+1])
        );
    end

    // The last cell is the output register.
    assign link_stall[NCELL]    = i_out_stall;
    assign o_out_valid          = link_valid[NCELL];
    assign o_out_data.hue_deg   = link_data[NCELL].hue.quo;
    assign o_out_data.sat_pct   = link_data[NCELL].sat.quo[rgbhsl_pkg::PCT_W-1:0];
    assign o_out_data.lum_pct   = link_data[NCELL].lum.quo[rgbhsl_pkg::PCT_W-1:0];
    assign o_out_data.alpha_out = link_data[NCELL].alpha;

endmodule

// ----- rtl/core/rgbhsl_prep.sv -----
`timescale 1ns / 1ps

// Entry stage: finds the channel extremes and sets up the three divisions.
module rgbhsl_prep (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  rgbhsl_pkg::t_pixel_in  i_data,
    output logic                   o_stall,
    output logic                   o_valid,
    output rgbhsl_pkg::t_cell_data o_data,
    input  logic                   i_stall
);

    logic                   r_valid;
    rgbhsl_pkg::t_cell_data r_data;
    rgbhsl_pkg::t_cell_data n_data;
    logic                   ready;

    logic [7:0]         r_c, g_c, b_c;
    logic [7:0]         mx, mn, d;
    logic [8:0]         s, den;
    logic signed [11:0] e, kd, t;

    assign ready   = !r_valid || !i_stall;
    assign o_stall = !ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        r_c = i_data.red_in;
        g_c = i_data.green_in;
        b_c = i_data.blue_in;
        mx  = (r_c > g_c) ? r_c : g_c;
        mx  = (mx > b_c) ? mx : b_c;
        mn  = (r_c < g_c) ? r_c : g_c;
        mn  = (mn < b_c) ? mn : b_c;
        d   = mx - mn;
        s   = {1'b0, mx} + {1'b0, mn};
        den = (s > rgbhsl_pkg::CHAN_FULL) ? (rgbhsl_pkg::CHAN_TWICE - s) : s;

        // Red is tested first, then green, then blue.
        if (r_c == mx) begin
            kd = 12'sd0;
            e  = $signed({4'b0, g_c}) - $signed({4'b0, b_c});
        end else if (g_c == mx) begin
            kd = $signed({3'b0, d, 1'b0});
            e  = $signed({4'b0, b_c}) - $signed({4'b0, r_c});
        end else begin
            kd = $signed({2'b0, d, 2'b0});
            e  = $signed({4'b0, r_c}) - $signed({4'b0, g_c});
        end
        t = kd + e;
        if (t < 0) begin
            t = t + $signed(12'(d) * 12'd6);
        end

        n_data.alpha    = i_data.alpha_in;
        n_data.lum.rem  = rgbhsl_pkg::REM_W'(s) * rgbhsl_pkg::REM_W'(100);
        n_data.lum.div  = rgbhsl_pkg::LUM_DIVISOR;
        n_data.lum.quo  = '0;
        n_data.sat.quo  = '0;
        n_data.hue.quo  = '0;
        if (d == 8'd0) begin
            // Grey pixel: a zero over one gives zero hue and saturation.
            n_data.sat.rem = '0;
            n_data.sat.div = rgbhsl_pkg::DIV_W'(1);
            n_data.hue.rem = '0;
            n_data.hue.div = rgbhsl_pkg::DIV_W'(1);
        end else begin
            n_data.sat.rem = rgbhsl_pkg::REM_W'(d) * rgbhsl_pkg::REM_W'(100);
            n_data.sat.div = den;
            n_data.hue.rem = rgbhsl_pkg::REM_W'(unsigned'(t)) * rgbhsl_pkg::REM_W'(60);
            n_data.hue.div = rgbhsl_pkg::DIV_W'(d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- rtl/core/rgbhsl_cell.sv -----
`timescale 1ns / 1ps

// One link of the divider chain: resolves quotient bit SHIFT of all three lanes.
module rgbhsl_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  rgbhsl_pkg::t_cell_data i_data,
    output logic                   o_stall,
    output logic                   o_valid,
    output rgbhsl_pkg::t_cell_data o_data,
    input  logic                   i_stall
);

    logic                   r_valid;
    rgbhsl_pkg::t_cell_data r_data;
    rgbhsl_pkg::t_cell_data n_data;
    logic                   ready;

    assign ready   = !r_valid || !i_stall;
    assign o_stall = !ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data       = i_data;
        n_data.hue   = rgbhsl_pkg::div_step(i_data.hue, SHIFT);
        n_data.sat   = rgbhsl_pkg::div_step(i_data.sat, SHIFT);
        n_data.lum   = rgbhsl_pkg::div_step(i_data.lum, SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- rtl/core/rgbhsl_checker.sv -----
`timescale 1ns / 1ps

module rgbhsl_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input rgbhsl_pkg::t_pixel_in  i_in_data,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input rgbhsl_pkg::t_pixel_out o_out_data
);

    // A held result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction changed while stalled");

    // Results stay within their documented ranges.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.hue_deg < 9'd360) && (o_out_data.sat_pct <= 7'd100)
                        && (o_out_data.lum_pct <= 7'd100))
        else $error("result field out of range");

    // The input is only held back when a result is waiting on the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without an output stall");

    // Reset leaves no result behind.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

endmodule

bind rgb_to_hsl_converter rgbhsl_checker u_rgbhsl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
